/* hdl/imhdk_pkg.sv */
// package for the indexed min-heap with decrease-key
// holds field widths, parameter defaults, codes and controller/datapath interface types
// no dependencies
`default_nettype none

package imhdk_pkg;

  localparam int NUM_KEYS_DEF      = 1024;
  localparam int PRIORITY_BITS_DEF = 32;

  localparam int KEY_W    = 10;
  localparam int PRIO_W   = 32;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 11;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DECREASED = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_MAP_RD,
    OP_CUR_RD,
    OP_INSERT,
    OP_DECREASE,
    OP_UP,
    OP_UP_CMP,
    OP_POP_RD,
    OP_POP_TAKE,
    OP_DN_RD,
    OP_DN_CMP,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_MAPD,
    S_CUR,
    S_UP,
    S_UPC,
    S_POP,
    S_POPT,
    S_DN,
    S_DNC,
    S_DONE
  } ctl_state_e;

  typedef struct packed {
    dp_op_e  op;
    logic    set_st;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic key_ok;
    logic present;
    logic full;
    logic dec_ok;
    logic s_zero;
    logic up_swap;
    logic dn_self;
    logic count_zero;
    logic count_one;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hdl/imhdk_ctrl.sv */
// controller state machine of the indexed min-heap
// sequences lookups, sift-up and sift-down steps; depends on imhdk_pkg
`default_nettype none

module imhdk_ctrl import imhdk_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     command_i,
  output logic          in_stall_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (stat_i.clr_done) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) state_d = command_i ? S_POP : S_MAP;
      end
      S_MAP:  state_d = stat_i.key_ok ? S_MAPD : S_DONE;
      S_MAPD: begin
        if (stat_i.present) state_d = S_CUR;
        else if (stat_i.full) state_d = S_DONE;
        else state_d = S_UP;
      end
      S_CUR:  state_d = stat_i.dec_ok ? S_UP : S_DONE;
      S_UP:   state_d = stat_i.s_zero ? S_DONE : S_UPC;
      S_UPC:  state_d = stat_i.up_swap ? S_UP : S_DONE;
      S_POP:  state_d = stat_i.count_zero ? S_DONE : S_POPT;
      S_POPT: state_d = stat_i.count_one ? S_DONE : S_DN;
      S_DN:   state_d = S_DNC;
      S_DNC:  state_d = stat_i.dn_self ? S_DONE : S_DN;
      S_DONE: if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '{op: OP_NONE, set_st: 1'b0, st: ST_IGNORED};
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_CLEAR: cmd_o.op = OP_CLEAR;
      S_IDLE:  if (in_valid_i) cmd_o.op = OP_CAPTURE;
      S_MAP: begin
        if (stat_i.key_ok) begin
          cmd_o.op = OP_MAP_RD;
        end else begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_IGNORED;
        end
      end
      S_MAPD: begin
        if (stat_i.present) begin
          cmd_o.op = OP_CUR_RD;
        end else if (stat_i.full) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_IGNORED;
        end else begin
          cmd_o.op     = OP_INSERT;
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_INSERTED;
        end
      end
      S_CUR: begin
        cmd_o.set_st = 1'b1;
        if (stat_i.dec_ok) begin
          cmd_o.op = OP_DECREASE;
          cmd_o.st = ST_DECREASED;
        end else begin
          cmd_o.st = ST_IGNORED;
        end
      end
      S_UP:  cmd_o.op = OP_UP;
      S_UPC: cmd_o.op = OP_UP_CMP;
      S_POP: begin
        if (stat_i.count_zero) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = ST_EMPTY;
        end else begin
          cmd_o.op = OP_POP_RD;
        end
      end
      S_POPT: begin
        cmd_o.op     = OP_POP_TAKE;
        cmd_o.set_st = 1'b1;
        cmd_o.st     = ST_POPPED;
      end
      S_DN:   cmd_o.op = OP_DN_RD;
      S_DNC:  cmd_o.op = OP_DN_CMP;
      S_DONE: if (stat_i.out_free) cmd_o.op = OP_EMIT;
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/imhdk_dp.sv */
// datapath of the indexed min-heap: heap and key-to-slot memories, moving entry, result register
// executes one controller op per cycle; depends on imhdk_pkg
`default_nettype none

module imhdk_dp import imhdk_pkg::*; #(
  parameter int NUM_KEYS      = NUM_KEYS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  output dp_stat_t               stat_o,
  input  wire logic [KEY_W-1:0]  key_i,
  input  wire logic [PRIO_W-1:0] priority_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [KEY_W-1:0]       out_key_o,
  output logic [PRIO_W-1:0]      out_priority_o,
  output logic [OCC_W-1:0]       occupancy_o
);

  localparam int KW = $clog2(NUM_KEYS);
  localparam int CW = $clog2(NUM_KEYS + 1);
  localparam int PW = PRIORITY_BITS;

  logic [KW-1:0] heap_key_mem  [NUM_KEYS];
  logic [PW-1:0] heap_prio_mem [NUM_KEYS];
  logic [KW:0]   map_mem       [NUM_KEYS];

  logic [KW-1:0]    clr_q;
  logic [CW-1:0]    count_q, count_d;
  logic [KEY_W-1:0] key_q;
  logic [PW-1:0]    prio_q;
  logic [KW-1:0]    s_q, cur_q, mov_key_q;
  logic [PW-1:0]    mov_prio_q;
  logic [KW-1:0]    rd_a_key_q, rd_b_key_q;
  logic [PW-1:0]    rd_a_prio_q, rd_b_prio_q;
  logic [KW:0]      map_rd_q;
  status_e          res_st_q;
  logic [KW-1:0]    res_key_q;
  logic [PW-1:0]    res_prio_q;
  logic             out_valid_q;
  status_e          out_st_q;
  logic [KEY_W-1:0] out_key_q;
  logic [PRIO_W-1:0] out_prio_q;
  logic [OCC_W-1:0] out_occ_q;

  logic          rd_en, map_re, hw_en, mw_en;
  logic [KW-1:0] rd_a_addr, rd_b_addr, hw_addr, hw_key, mw_addr, map_ra;
  logic [PW-1:0] hw_prio;
  logic [KW:0]   mw_data;

  logic [KW-1:0] parent;
  logic [KW+1:0] left_ix, right_ix;
  logic          l_ok, r_ok, left_win, right_win;
  logic [PW-1:0] mid_prio;
  logic [KW-1:0] key_ix;
  logic          out_free;

  assign key_ix   = KW'(key_q);
  assign parent   = KW'((s_q - KW'(1)) >> 1);
  assign left_ix  = ({2'b00, s_q} << 1) + (KW+2)'(1);
  assign right_ix = ({2'b00, s_q} << 1) + (KW+2)'(2);
  assign l_ok     = left_ix < (KW+2)'(count_q);
  assign r_ok     = right_ix < (KW+2)'(count_q);
  // left child first, then right against the smaller so far
  assign left_win  = l_ok && (rd_a_prio_q < mov_prio_q);
  assign mid_prio  = left_win ? rd_a_prio_q : mov_prio_q;
  assign right_win = r_ok && (rd_b_prio_q < mid_prio);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    stat_o.clr_done   = (clr_q == KW'(NUM_KEYS - 1));
    stat_o.key_ok     = (int'(key_q) < NUM_KEYS);
    stat_o.present    = map_rd_q[KW];
    stat_o.full       = (count_q == CW'(NUM_KEYS));
    stat_o.dec_ok     = (prio_q < rd_a_prio_q);
    stat_o.s_zero     = (s_q == '0);
    stat_o.up_swap    = (mov_prio_q < rd_a_prio_q);
    stat_o.dn_self    = !left_win && !right_win;
    stat_o.count_zero = (count_q == '0);
    stat_o.count_one  = (count_q == CW'(1));
    stat_o.out_free   = out_free;
  end

  // memory port steering
  always_comb begin
    rd_en     = 1'b0;
    rd_a_addr = s_q;
    rd_b_addr = s_q;
    map_re    = 1'b0;
    map_ra    = key_ix;
    hw_en     = 1'b0;
    hw_addr   = s_q;
    hw_key    = mov_key_q;
    hw_prio   = mov_prio_q;
    mw_en     = 1'b0;
    mw_addr   = mov_key_q;
    mw_data   = {1'b1, s_q};
    count_d   = count_q;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        mw_en   = 1'b1;
        mw_addr = clr_q;
        mw_data = '0;
      end
      OP_MAP_RD: map_re = 1'b1;
      OP_CUR_RD: begin
        rd_en     = 1'b1;
        rd_a_addr = map_rd_q[KW-1:0];
      end
      OP_INSERT: count_d = count_q + CW'(1);
      OP_UP: begin
        if (s_q == '0) begin
          hw_en = 1'b1;
          mw_en = 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_a_addr = parent;
        end
      end
      OP_UP_CMP: begin
        hw_en = 1'b1;
        mw_en = 1'b1;
        if (mov_prio_q < rd_a_prio_q) begin
          hw_key  = rd_a_key_q;
          hw_prio = rd_a_prio_q;
          mw_addr = rd_a_key_q;
        end
      end
      OP_POP_RD: begin
        rd_en     = 1'b1;
        rd_a_addr = '0;
        rd_b_addr = KW'(count_q - CW'(1));
      end
      OP_POP_TAKE: begin
        mw_en   = 1'b1;
        mw_addr = rd_a_key_q;
        mw_data = '0;
        count_d = count_q - CW'(1);
      end
      OP_DN_RD: begin
        rd_en     = 1'b1;
        rd_a_addr = KW'(left_ix);
        rd_b_addr = KW'(right_ix);
      end
      OP_DN_CMP: begin
        hw_en = 1'b1;
        mw_en = 1'b1;
        if (right_win) begin
          hw_key  = rd_b_key_q;
          hw_prio = rd_b_prio_q;
          mw_addr = rd_b_key_q;
        end else if (left_win) begin
          hw_key  = rd_a_key_q;
          hw_prio = rd_a_prio_q;
          mw_addr = rd_a_key_q;
        end
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (hw_en) begin
      heap_key_mem[hw_addr]  <= hw_key;
      heap_prio_mem[hw_addr] <= hw_prio;
    end
    if (rd_en) begin
      rd_a_key_q  <= heap_key_mem[rd_a_addr];
      rd_a_prio_q <= heap_prio_mem[rd_a_addr];
      rd_b_key_q  <= heap_key_mem[rd_b_addr];
      rd_b_prio_q <= heap_prio_mem[rd_b_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mw_en) begin
      map_mem[mw_addr] <= mw_data;
    end
    if (map_re) begin
      map_rd_q <= map_mem[map_ra];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + KW'(1);
      count_q <= count_d;
      if (cmd_i.op == OP_EMIT) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        key_q      <= key_i;
        prio_q     <= PW'(priority_req_i);
        res_key_q  <= '0;
        res_prio_q <= '0;
      end
      OP_CUR_RD: cur_q <= map_rd_q[KW-1:0];
      OP_INSERT: begin
        s_q        <= KW'(count_q);
        mov_key_q  <= key_ix;
        mov_prio_q <= prio_q;
      end
      OP_DECREASE: begin
        s_q        <= cur_q;
        mov_key_q  <= key_ix;
        mov_prio_q <= prio_q;
      end
      OP_UP_CMP: if (mov_prio_q < rd_a_prio_q) s_q <= parent;
      OP_POP_TAKE: begin
        res_key_q  <= rd_a_key_q;
        res_prio_q <= rd_a_prio_q;
        mov_key_q  <= rd_b_key_q;
        mov_prio_q <= rd_b_prio_q;
        s_q        <= '0;
      end
      OP_DN_CMP: begin
        if (right_win) s_q <= KW'(right_ix);
        else if (left_win) s_q <= KW'(left_ix);
      end
      OP_EMIT: begin
        out_st_q   <= res_st_q;
        out_key_q  <= KEY_W'(res_key_q);
        out_prio_q <= PRIO_W'(res_prio_q);
        out_occ_q  <= OCC_W'(count_q);
      end
      default: ;
    endcase
    if (cmd_i.set_st) res_st_q <= cmd_i.st;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign out_key_o      = out_key_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = out_occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(NUM_KEYS)) else $error("heap count beyond capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_INSERT |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the heap");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_en |-> (CW+1)'(hw_addr) < (CW+1)'(count_q))
    else $error("heap write outside occupied slots");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_EMIT |=> out_valid_q) else $error("emitted result not presented");

endmodule

`default_nettype wire

/* hdl/indexed_min_heap_decrease_key_top.sv */
// top level of the indexed binary min-heap with decrease-key
// instantiates imhdk_ctrl and imhdk_dp; depends on imhdk_pkg
//
// usage
//   input channel: in_valid_i / in_stall_o carry one transaction of command_i, key_i and
//   priority_req_i; command 0 pushes a key or lowers its priority, command 1 pops the minimum
//   output channel: out_valid_o / out_stall_i carry one result transaction per input transaction
//   with status_o, out_key_o, out_priority_o and occupancy_o after the operation
//   a push looks up the key-to-slot entry and then sifts up, a pop takes the root and then
//   sifts down; one transaction is worked on at a time, each sift level being one registered
//   read of the heap memory followed by a compare and a write
//   the result sits in an output register, so a new transaction is taken while the previous
//   result still waits; a stalled receiver only holds the block once a second result is ready
//   reset: the heap empties and a clearing pass writes every key-to-slot entry as absent,
//   during which in_stall_o stays high
//   ties pop in array-heap order: sift-up swaps on strictly less, sift-down checks the left
//   child first, then the right
`default_nettype none

module indexed_min_heap_decrease_key_top import imhdk_pkg::*; #(
  parameter int NUM_KEYS      = NUM_KEYS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              command_i,
  input  wire logic [KEY_W-1:0]  key_i,
  input  wire logic [PRIO_W-1:0] priority_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [KEY_W-1:0]       out_key_o,
  output logic [PRIO_W-1:0]      out_priority_o,
  output logic [OCC_W-1:0]       occupancy_o
);

  // command and status between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  imhdk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  imhdk_dp #(
    .NUM_KEYS      (NUM_KEYS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .key_i          (key_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_key_o      (out_key_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

`default_nettype wire
